// ===== rtl/spqv_pkg.sv =====
// Shared types and constants for the sprite quad vertex expander.
package spqv_pkg;

    localparam logic [1:0] MODE_COLOR  = 2'd0;
    localparam logic [1:0] MODE_TEX    = 2'd1;
    localparam logic [1:0] MODE_SCENE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // quarter-wave polynomial coefficients
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [11:0] SIN_C = 12'd2320;

    localparam logic signed [16:0] COS_ONE = 17'sd32768;
    localparam logic [15:0]        WHITE   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_w;
        logic signed [31:0] size_h;
        logic [15:0]        angle;
        logic [15:0]        color_r;
        logic [15:0]        color_g;
        logic [15:0]        color_b;
        logic [15:0]        color_a;
        logic [15:0]        texture_id;
    } req_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [15:0]        vert_r;
        logic [15:0]        vert_g;
        logic [15:0]        vert_b;
        logic [15:0]        vert_a;
        logic               tex_u;
        logic               tex_v;
        logic [3:0]         tex_slot;
        logic               slot_overflow;
        logic               last;
    } vert_t;

    // one classified sprite handed from front to back
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_w;
        logic signed [31:0] size_h;
        logic signed [16:0] cos_v;
        logic signed [16:0] sin_v;
        logic [15:0]        r;
        logic [15:0]        g;
        logic [15:0]        b;
        logic [15:0]        a;
        logic [3:0]         slot;
        logic               ovf;
    } job_t;

endpackage

// ===== rtl/sprite_quad_vertex_expander.sv =====
// Sprite quad vertex expander top level.
// Path: a request passes the front-end sequencer, the job queue, the back-end registers
// and the vertex queue; rotation first runs sine then cosine, a texture first searches the slots.
// Throughput: back end emits one vertex a cycle while the vertex queue has room, four per
// sprite; the front end takes no new request until a colored or textured quad is pushed as a job.
// Reset: asynchronous, clears queues and state; slot count returns to one.
module sprite_quad_vertex_expander #(
    parameter int SLOT_COUNT = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  spqv_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output spqv_pkg::vert_t vert
);

    logic            job_push;
    logic            job_full;
    logic            job_empty;
    logic            job_pop;
    spqv_pkg::job_t  job_in;
    spqv_pkg::job_t  job_out;
    logic            vpush;
    logic            vfull;
    spqv_pkg::vert_t vert_in;

    spqv_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .req      (req),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    spqv_queue #(.T(spqv_pkg::job_t)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    spqv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .vpush     (vpush),
        .vert      (vert_in),
        .vfull     (vfull)
    );

    spqv_queue #(.T(spqv_pkg::vert_t)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (vpush),
        .din   (vert_in),
        .full  (vfull),
        .pop   (pop),
        .dout  (vert),
        .empty (empty)
    );

    // begin-scene beat leaves the front end free to accept in the next cycle
    a_scene_quick: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && req.mode == spqv_pkg::MODE_SCENE |=> !full)
        else $error("front busy after begin-scene beat");

    // overflow vertices always use the white slot
    a_ovf_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && vert.slot_overflow |-> vert.tex_slot == 4'd0)
        else $error("overflow vertex with non-zero slot");

    // the back end never pushes into a full result queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        vpush |-> !vfull)
        else $error("vertex pushed into full queue");

endmodule

// ===== rtl/spqv_queue.sv =====
// Two-entry queue carrying one packed payload type.
module spqv_queue #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    T           mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // store incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/spqv_sine.sv =====
// Iterative Q1.15 sine unit, one multiply per cycle.
module spqv_sine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [16:0] result
);

    localparam logic [11:0] SIN_C_EXT = spqv_pkg::SIN_C;

    logic [2:0]         step_reg;
    logic               neg_reg;
    logic [14:0]        t_reg;
    logic [14:0]        t2_reg;
    logic [15:0]        acc_reg;
    logic               done_reg;
    logic signed [16:0] result_reg;

    logic [14:0] phase;
    logic [29:0] p_tt;
    logic [26:0] p_c;
    logic [30:0] p_acc_t2;
    logic [30:0] p_acc_t;
    logic [16:0] f;
    logic [16:0] f_clamp;

    assign phase    = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign p_tt     = t_reg * t_reg;
    assign p_c      = SIN_C_EXT * t2_reg;
    assign p_acc_t2 = acc_reg * t2_reg;
    assign p_acc_t  = acc_reg * t_reg;
    assign f        = p_acc_t[30:14];
    assign f_clamp  = (f > 17'd32767) ? 17'd32767 : f;

    assign done   = done_reg;
    assign result = result_reg;

    // step through the polynomial, one product per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg == 3'd4)
            begin
                step_reg <= 3'd0;
                done_reg <= 1'b1;
            end
            else if (step_reg != 3'd0)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t_reg   <= phase;
            neg_reg <= angle[15];
        end
        case (step_reg)
            3'd1: t2_reg  <= p_tt[28:14];
            3'd2: acc_reg <= spqv_pkg::SIN_B - {3'd0, p_c[26:14]};
            3'd3: acc_reg <= spqv_pkg::SIN_A - p_acc_t2[29:14];
            3'd4: result_reg <= neg_reg ? -$signed(f_clamp) : $signed(f_clamp);
            default: ;
        endcase
    end

endmodule

// ===== rtl/spqv_front.sv =====
// Front end: accepts requests, resolves texture slots and computes sine and cosine.
module spqv_front #(
    parameter int SLOT_COUNT = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spqv_pkg::req_t  req,
    output logic            full,
    output logic            job_push,
    output spqv_pkg::job_t  job,
    input  logic            job_full
);

    localparam int SW = $clog2(SLOT_COUNT);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SRCH = 5'b00010,
        ST_SIN  = 5'b00100,
        ST_COS  = 5'b01000,
        ST_PUSH = 5'b10000
    } state_t;

    state_t              state_reg;
    spqv_pkg::req_t      item_reg;
    logic [15:0]         mem [SLOT_COUNT];
    logic [SW:0]         used_reg;
    logic [SW:0]         idx_reg;
    logic [SW:0]         chk_idx_reg;
    logic                chk_v_reg;
    logic [15:0]         rd_reg;
    logic [SW:0]         slot_reg;
    logic                ovf_reg;
    logic signed [16:0]  sin_reg;
    logic signed [16:0]  cos_reg;

    logic               accept;
    logic               issue;
    logic               hit;
    logic               miss;
    logic               room;
    logic               sin_start;
    logic [15:0]        sin_angle;
    logic               sin_done;
    logic signed [16:0] sin_res;
    logic               textured;

    assign full     = (state_reg != ST_IDLE);
    assign accept   = push && !full;
    assign issue    = (idx_reg < used_reg);
    assign hit      = chk_v_reg && (rd_reg == item_reg.texture_id);
    assign miss     = !hit && !issue && !chk_v_reg;
    assign room     = (used_reg < (SW+1)'(SLOT_COUNT));
    assign textured = (item_reg.mode == spqv_pkg::MODE_TEX);

    // launch sine first, then cosine at a quarter turn on
    assign sin_start = (accept && req.mode == spqv_pkg::MODE_COLOR && req.angle != 16'd0)
                    || (state_reg == ST_SIN && sin_done);
    assign sin_angle = (state_reg == ST_SIN) ? (item_reg.angle + 16'd16384) : req.angle;

    spqv_sine u_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sin_start),
        .angle  (sin_angle),
        .done   (sin_done),
        .result (sin_res)
    );

    // build the job beat
    always_comb
    begin
        job.pos_x  = item_reg.pos_x;
        job.pos_y  = item_reg.pos_y;
        job.pos_z  = item_reg.pos_z;
        job.size_w = item_reg.size_w;
        job.size_h = item_reg.size_h;
        job.cos_v  = textured ? spqv_pkg::COS_ONE : cos_reg;
        job.sin_v  = textured ? 17'sd0 : sin_reg;
        job.r      = textured ? spqv_pkg::WHITE : item_reg.color_r;
        job.g      = textured ? spqv_pkg::WHITE : item_reg.color_g;
        job.b      = textured ? spqv_pkg::WHITE : item_reg.color_b;
        job.a      = textured ? spqv_pkg::WHITE : item_reg.color_a;
        job.slot   = textured ? 4'(slot_reg) : 4'd0;
        job.ovf    = textured ? ovf_reg : 1'b0;
    end

    assign job_push = (state_reg == ST_PUSH) && !job_full;

    // slot table: write new identities, read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SRCH && miss && room)
        begin
            mem[used_reg[SW-1:0]] <= item_reg.texture_id;
        end
        if (issue)
        begin
            rd_reg <= mem[idx_reg[SW-1:0]];
        end
    end

    // hold the request and results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            cos_reg  <= spqv_pkg::COS_ONE;
            sin_reg  <= 17'sd0;
        end
        if (state_reg == ST_SIN && sin_done)
        begin
            sin_reg <= sin_res;
        end
        if (state_reg == ST_COS && sin_done)
        begin
            cos_reg <= sin_res;
        end
        if (state_reg == ST_SRCH)
        begin
            chk_idx_reg <= idx_reg;
            if (hit)
            begin
                slot_reg <= chk_idx_reg;
                ovf_reg  <= 1'b0;
            end
            else if (miss)
            begin
                slot_reg <= room ? used_reg : '0;
                ovf_reg  <= !room;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= (SW+1)'(1);
            idx_reg   <= (SW+1)'(1);
            chk_v_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.mode)
                            spqv_pkg::MODE_COLOR:
                                state_reg <= (req.angle != 16'd0) ? ST_SIN : ST_PUSH;
                            spqv_pkg::MODE_TEX:
                            begin
                                state_reg <= ST_SRCH;
                                idx_reg   <= (SW+1)'(1);
                                chk_v_reg <= 1'b0;
                            end
                            spqv_pkg::MODE_SCENE:
                                used_reg <= (SW+1)'(1);
                            default: ;
                        endcase
                    end
                end
                ST_SRCH:
                begin
                    chk_v_reg <= issue;
                    if (issue)
                    begin
                        idx_reg <= idx_reg + (SW+1)'(1);
                    end
                    if (hit)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else if (miss)
                    begin
                        state_reg <= ST_PUSH;
                        if (room)
                        begin
                            used_reg <= used_reg + (SW+1)'(1);
                        end
                    end
                end
                ST_SIN:
                begin
                    if (sin_done)
                    begin
                        state_reg <= ST_COS;
                    end
                end
                ST_COS:
                begin
                    if (sin_done)
                    begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!job_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/spqv_back.sv =====
// Back end: forms four corner vertices from one job.
module spqv_back (
    input  logic            clk,
    input  logic            rst_n,
    input  spqv_pkg::job_t  job,
    input  logic            job_empty,
    output logic            job_pop,
    output logic            vpush,
    output spqv_pkg::vert_t vert,
    input  logic            vfull
);

    logic               busy_reg;
    logic [1:0]         k_reg;
    spqv_pkg::job_t     job_reg;
    logic signed [48:0] wc_reg;
    logic signed [48:0] hs_reg;
    logic signed [48:0] ws_reg;
    logic signed [48:0] hc_reg;

    logic               neg_x;
    logic               neg_y;
    logic signed [49:0] dx;
    logic signed [49:0] dy;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [34:0] sum_x;
    logic signed [34:0] sum_y;

    localparam logic signed [34:0] MAXV = 35'sd2147483647;
    localparam logic signed [34:0] MINV = -35'sd2147483648;

    assign vpush   = busy_reg && !vfull;
    assign job_pop = !job_empty && (!busy_reg || (vpush && k_reg == 2'd3));

    // corner signs: x negative on corners 0 and 3, y on corners 0 and 1
    assign neg_x = (k_reg == 2'd0) || (k_reg == 2'd3);
    assign neg_y = (k_reg == 2'd0) || (k_reg == 2'd1);

    always_comb
    begin
        dx = (neg_x ? -50'(wc_reg) : 50'(wc_reg)) - (neg_y ? -50'(hs_reg) : 50'(hs_reg));
        dy = (neg_x ? -50'(ws_reg) : 50'(ws_reg)) + (neg_y ? -50'(hc_reg) : 50'(hc_reg));
        rx = 34'((dx + 50'sd32768) >>> 16);
        ry = 34'((dy + 50'sd32768) >>> 16);
        sum_x = 35'(job_reg.pos_x) + 35'(rx);
        sum_y = 35'(job_reg.pos_y) + 35'(ry);

        vert.vert_x = (sum_x > MAXV) ? 32'sh7FFFFFFF :
                      (sum_x < MINV) ? 32'sh80000000 : 32'(sum_x);
        vert.vert_y = (sum_y > MAXV) ? 32'sh7FFFFFFF :
                      (sum_y < MINV) ? 32'sh80000000 : 32'(sum_y);
        vert.vert_z        = job_reg.pos_z;
        vert.vert_r        = job_reg.r;
        vert.vert_g        = job_reg.g;
        vert.vert_b        = job_reg.b;
        vert.vert_a        = job_reg.a;
        vert.tex_u         = (k_reg == 2'd1) || (k_reg == 2'd2);
        vert.tex_v         = k_reg[1];
        vert.tex_slot      = job_reg.slot;
        vert.slot_overflow = job_reg.ovf;
        vert.last          = (k_reg == 2'd3);
    end

    // take products once per job
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
            wc_reg  <= 49'(job.size_w * job.cos_v);
            hs_reg  <= 49'(job.size_h * job.sin_v);
            ws_reg  <= 49'(job.size_w * job.sin_v);
            hc_reg  <= 49'(job.size_h * job.cos_v);
        end
    end

    // advance the corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= 2'd0;
        end
        else
        begin
            if (vpush)
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (job_pop)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

endmodule
